FILE: rtl/xt_keyboard_receiver_macros.svh
// Assertion macros shared by the XT keyboard receiver RTL.
// No dependencies; included by the files that carry assertions.
`ifndef XT_KEYBOARD_RECEIVER_MACROS_SVH
`define XT_KEYBOARD_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
`define XTKR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define XTKR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define XTKR_ASSERT_NOW(label, ante, cons, msg)
`define XTKR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/xtkr_pkg.sv
// Types and constants for the XT keyboard receiver.
// No dependencies; used by every module of the block.
package xtkr_pkg;

    localparam int unsigned DATA_BITS  = 8;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned GAP_W      = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned PADDR_W    = 4;
    localparam int unsigned PDATA_W    = 32;

    localparam logic [1:0] REG_MIN_EDGE_GAP = 2'd0;
    localparam logic [1:0] REG_MAX_EDGE_GAP = 2'd1;
    localparam logic [1:0] REG_MIN_IDLE_GAP = 2'd2;

    localparam logic [GAP_W-1:0] MIN_EDGE_GAP_RESET = 16'd13;
    localparam logic [GAP_W-1:0] MAX_EDGE_GAP_RESET = 16'd120;
    localparam logic [GAP_W-1:0] MIN_IDLE_GAP_RESET = 16'd200;

    localparam logic [1:0] VERDICT_ACCEPTED  = 2'd0;
    localparam logic [1:0] VERDICT_TOO_CLOSE = 2'd1;
    localparam logic [1:0] VERDICT_TOO_SOON  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_START = 4'd0;
    localparam logic [CNT_W-1:0] CNT_LAST  = 4'd8;

    typedef struct packed {
        logic [TIME_W-1:0] edge_time_us;
        logic              data_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       edge_verdict;
        logic             resynced;
        logic             byte_done;
        logic [7:0]       byte_value;
        logic [CNT_W-1:0] bit_position;
    } out_item_t;

    typedef struct packed {
        logic [GAP_W-1:0] min_edge_gap_us;
        logic [GAP_W-1:0] max_edge_gap_us;
        logic [GAP_W-1:0] min_idle_gap_us;
    } cfg_t;

endpackage

FILE: rtl/xtkr_cfg_regs.sv
// APB register file holding the three timing limits of the receiver.
// Depends on xtkr_pkg.
module xtkr_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [xtkr_pkg::PADDR_W-1:0]   paddr,
    input  logic [xtkr_pkg::PDATA_W-1:0]   pwdata,
    output logic [xtkr_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output xtkr_pkg::cfg_t                 cfg
);

    xtkr_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[3:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_edge_gap_us <= xtkr_pkg::MIN_EDGE_GAP_RESET;
            cfg_reg.max_edge_gap_us <= xtkr_pkg::MAX_EDGE_GAP_RESET;
            cfg_reg.min_idle_gap_us <= xtkr_pkg::MIN_IDLE_GAP_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                xtkr_pkg::REG_MIN_EDGE_GAP:
                    cfg_reg.min_edge_gap_us <= pwdata[xtkr_pkg::GAP_W-1:0];
                xtkr_pkg::REG_MAX_EDGE_GAP:
                    cfg_reg.max_edge_gap_us <= pwdata[xtkr_pkg::GAP_W-1:0];
                xtkr_pkg::REG_MIN_IDLE_GAP:
                    cfg_reg.min_idle_gap_us <= pwdata[xtkr_pkg::GAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            xtkr_pkg::REG_MIN_EDGE_GAP:
                prdata = {16'd0, cfg_reg.min_edge_gap_us};
            xtkr_pkg::REG_MAX_EDGE_GAP:
                prdata = {16'd0, cfg_reg.max_edge_gap_us};
            xtkr_pkg::REG_MIN_IDLE_GAP:
                prdata = {16'd0, cfg_reg.min_idle_gap_us};
            default:
                prdata = '0;
        endcase
    end

endmodule

FILE: rtl/xtkr_edge_core.sv
// Receiver state and the per-edge decision logic: gap filtering and bit assembly.
// Depends on xtkr_pkg and xt_keyboard_receiver_macros.svh.
`include "xt_keyboard_receiver_macros.svh"

module xtkr_edge_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  xtkr_pkg::in_item_t  item,
    input  xtkr_pkg::cfg_t      cfg,
    output xtkr_pkg::out_item_t result
);

    logic [xtkr_pkg::TIME_W-1:0] last_time_reg;
    logic [xtkr_pkg::TIME_W-1:0] last_time_next;
    logic                        time_valid_reg;
    logic                        time_valid_next;
    logic [xtkr_pkg::CNT_W-1:0]  cnt_reg;
    logic [xtkr_pkg::CNT_W-1:0]  cnt_next;
    logic [7:0]                  byte_reg;
    logic [7:0]                  byte_next;

    logic [xtkr_pkg::TIME_W-1:0] gap;
    logic                        too_close;
    logic                        long_gap;
    logic                        too_soon;
    logic                        accepted;
    logic [xtkr_pkg::CNT_W-1:0]  cnt_mid;
    logic [7:0]                  byte_mid;
    logic [7:0]                  byte_ins;

    assign gap       = item.edge_time_us - last_time_reg;
    assign too_close = time_valid_reg
                     && (gap < {16'd0, cfg.min_edge_gap_us});
    assign long_gap  = time_valid_reg
                     && (gap > {16'd0, cfg.max_edge_gap_us})
                     && (cnt_reg != xtkr_pkg::CNT_START);
    assign cnt_mid   = long_gap ? xtkr_pkg::CNT_START : cnt_reg;
    assign byte_mid  = long_gap ? 8'd0 : byte_reg;
    assign too_soon  = (cnt_mid == xtkr_pkg::CNT_START) && time_valid_reg
                     && (gap < {16'd0, cfg.min_idle_gap_us});
    assign accepted  = !too_close && !too_soon;

    always_comb
    begin
        byte_ins = byte_mid;
        for (int i = 0; i < xtkr_pkg::DATA_BITS; i++)
        begin
            if (cnt_mid == xtkr_pkg::CNT_W'(i + 1))
            begin
                byte_ins[i] = byte_mid[i] | item.data_level;
            end
        end
    end

    always_comb
    begin
        last_time_next      = last_time_reg;
        time_valid_next     = time_valid_reg;
        cnt_next            = cnt_reg;
        byte_next           = byte_reg;
        result.edge_verdict = xtkr_pkg::VERDICT_ACCEPTED;
        result.resynced     = 1'b0;
        result.byte_done    = 1'b0;
        result.byte_value   = 8'd0;

        if (too_close)
        begin
            result.edge_verdict = xtkr_pkg::VERDICT_TOO_CLOSE;
        end
        else
        begin
            result.resynced = long_gap;
            cnt_next        = cnt_mid;
            byte_next       = byte_mid;
            if (too_soon)
            begin
                result.edge_verdict = xtkr_pkg::VERDICT_TOO_SOON;
            end
            else
            begin
                last_time_next  = item.edge_time_us;
                time_valid_next = 1'b1;
                if (cnt_mid == xtkr_pkg::CNT_START)
                begin
                    byte_next = 8'd0;
                    cnt_next  = 4'd1;
                end
                else if (cnt_mid < xtkr_pkg::CNT_LAST)
                begin
                    byte_next = byte_ins;
                    cnt_next  = cnt_mid + 4'd1;
                end
                else if (cnt_mid == xtkr_pkg::CNT_LAST)
                begin
                    result.byte_done  = 1'b1;
                    result.byte_value = byte_ins;
                    byte_next         = 8'd0;
                    cnt_next          = xtkr_pkg::CNT_START;
                end
                else
                begin
                    byte_next = 8'd0;
                    cnt_next  = xtkr_pkg::CNT_START;
                end
            end
        end
        result.bit_position = cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg  <= '0;
            time_valid_reg <= 1'b0;
            cnt_reg        <= xtkr_pkg::CNT_START;
            byte_reg       <= 8'd0;
        end
        else if (fire)
        begin
            last_time_reg  <= last_time_next;
            time_valid_reg <= time_valid_next;
            cnt_reg        <= cnt_next;
            byte_reg       <= byte_next;
        end
    end

    `XTKR_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg <= xtkr_pkg::CNT_LAST, "bit counter out of range")
    `XTKR_ASSERT_NEXT(a_time_held, !(fire && accepted), $stable(last_time_reg), "time moved on an ignored edge")
    `XTKR_ASSERT_NEXT(a_valid_kept, time_valid_reg, time_valid_reg, "last time valid flag dropped")
    `XTKR_ASSERT_NOW(a_done_restart, fire && result.byte_done, result.bit_position == xtkr_pkg::CNT_START && byte_next == 8'd0, "completed byte did not restart assembly")

endmodule

FILE: rtl/xt_keyboard_receiver.sv
// An accepted edge item is registered in in_item_reg; its result is computed from there and registered
// in out_item_reg, where it stays valid until result_ready takes it.
// Throughput: one edge item per cycle while the output register is empty or result_ready is high.
// Reset (rst_n, asynchronous, active low) clears the receiver state and the valid flags of both
// pipeline registers and loads the limits 13, 120 and 200 us; items are accepted straight away.
// Top level of the XT keyboard receiver; depends on xtkr_pkg, xtkr_cfg_regs and xtkr_edge_core.
module xt_keyboard_receiver
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          edge_valid,
    output logic                          edge_ready,
    input  xtkr_pkg::in_item_t            edge_item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output xtkr_pkg::out_item_t           result_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [xtkr_pkg::PADDR_W-1:0]  paddr,
    input  logic [xtkr_pkg::PDATA_W-1:0]  pwdata,
    output logic [xtkr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    xtkr_pkg::cfg_t      cfg;
    xtkr_pkg::in_item_t  in_item_reg;
    logic                in_valid_reg;
    xtkr_pkg::out_item_t out_item_reg;
    logic                out_valid_reg;
    xtkr_pkg::out_item_t core_result;
    logic                advance;
    logic                fire;

    assign advance      = !out_valid_reg || result_ready;
    assign fire         = in_valid_reg && advance;
    assign edge_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    xtkr_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    xtkr_edge_core u_edge_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (edge_ready)
            begin
                in_valid_reg <= edge_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_ready && edge_valid)
        begin
            in_item_reg <= edge_item;
        end
        if (fire)
        begin
            out_item_reg <= core_result;
        end
    end

endmodule

FILE: verif/xt_keyboard_receiver_tb.sv
// Self-checking testbench for the XT keyboard serial receiver: edge items in, one verdict per edge.
// Depends on xtkr_pkg and xt_keyboard_receiver; the limits are set through the APB port.
`timescale 1ns / 1ps

module xt_keyboard_receiver_tb;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           edge_valid = 1'b0;
    logic                           edge_ready;
    xtkr_pkg::in_item_t             edge_item = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    xtkr_pkg::out_item_t            result_item;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [xtkr_pkg::PADDR_W-1:0]   paddr = '0;
    logic [xtkr_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [xtkr_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    xt_keyboard_receiver uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .edge_ready   (edge_ready),
        .edge_item    (edge_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Limits as last written, and the receiver state that the expected verdicts follow.
    logic [xtkr_pkg::GAP_W-1:0]   cfg_min_gap = xtkr_pkg::MIN_EDGE_GAP_RESET;
    logic [xtkr_pkg::GAP_W-1:0]   cfg_max_gap = xtkr_pkg::MAX_EDGE_GAP_RESET;
    logic [xtkr_pkg::GAP_W-1:0]   cfg_idle_gap = xtkr_pkg::MIN_IDLE_GAP_RESET;
    logic [xtkr_pkg::TIME_W-1:0]  kb_last_time = '0;
    logic                         kb_time_known = 1'b0;
    logic [xtkr_pkg::CNT_W-1:0]   kb_bit_cnt = xtkr_pkg::CNT_START;
    logic [7:0]                   kb_shift = '0;

    xtkr_pkg::in_item_t           pending_edges[$];
    xtkr_pkg::out_item_t          expected_results[$];
    logic [xtkr_pkg::TIME_W-1:0]  stim_time = '0;

    int unsigned edges_pushed = 0;
    int unsigned edges_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned settings_used = 1;
    int unsigned bytes_seen = 0;
    int unsigned resyncs_seen = 0;
    int unsigned too_close_seen = 0;
    int unsigned too_soon_seen = 0;

    int unsigned send_burst_left = 0;
    int unsigned send_gap_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_mode_timer = 0;
    int unsigned rx_hold_left = 0;
    logic        rx_hold_done = 1'b0;
    logic [1:0]  rx_cycle = '0;

    function automatic xtkr_pkg::out_item_t predict_edge(input xtkr_pkg::in_item_t item);
        xtkr_pkg::out_item_t         res;
        logic [xtkr_pkg::TIME_W-1:0] gap;
        res = '0;
        gap = item.edge_time_us - kb_last_time;
        if (kb_time_known && gap < {16'd0, cfg_min_gap})
            res.edge_verdict = xtkr_pkg::VERDICT_TOO_CLOSE;
        else
        begin
            // A lost edge mid-byte drops the partial byte even if the edge is then ignored.
            if (kb_time_known && gap > {16'd0, cfg_max_gap}
                && kb_bit_cnt != xtkr_pkg::CNT_START)
            begin
                kb_bit_cnt = xtkr_pkg::CNT_START;
                kb_shift = '0;
                res.resynced = 1'b1;
            end
            if (kb_bit_cnt == xtkr_pkg::CNT_START && kb_time_known
                && gap < {16'd0, cfg_idle_gap})
                res.edge_verdict = xtkr_pkg::VERDICT_TOO_SOON;
            else
            begin
                res.edge_verdict = xtkr_pkg::VERDICT_ACCEPTED;
                kb_last_time = item.edge_time_us;
                kb_time_known = 1'b1;
                if (kb_bit_cnt == xtkr_pkg::CNT_START)
                begin
                    kb_shift = '0;
                    kb_bit_cnt = 4'd1;
                end
                else if (kb_bit_cnt < xtkr_pkg::CNT_LAST)
                begin
                    kb_shift[3'(kb_bit_cnt - 4'd1)] = item.data_level;
                    kb_bit_cnt = kb_bit_cnt + 4'd1;
                end
                else if (kb_bit_cnt == xtkr_pkg::CNT_LAST)
                begin
                    res.byte_done = 1'b1;
                    res.byte_value = {item.data_level, kb_shift[6:0]};
                    kb_bit_cnt = xtkr_pkg::CNT_START;
                    kb_shift = '0;
                end
                else
                begin
                    kb_bit_cnt = xtkr_pkg::CNT_START;
                    kb_shift = '0;
                end
            end
        end
        res.bit_position = kb_bit_cnt;
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (edge_valid && edge_ready)
            begin
                expected_results.push_back(predict_edge(edge_item));
                edges_accepted++;
            end
            if (!edge_valid || edge_ready)
            begin
                if (send_gap_left != 0)
                begin
                    send_gap_left--;
                    edge_valid <= 1'b0;
                end
                else if (pending_edges.size() != 0)
                begin
                    edge_item <= pending_edges.pop_front();
                    edge_valid <= 1'b1;
                    if (send_burst_left > 1)
                        send_burst_left--;
                    else
                    begin
                        send_burst_left = $urandom_range(1, 24);
                        send_gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
                else
                    edge_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each item against the oldest expectation and stalls on its own pattern.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item arrived with none expected");
                mismatch_count++;
            end
            else
            begin
                xtkr_pkg::out_item_t want;
                want = expected_results.pop_front();
                check_field("edge_verdict", 32'(want.edge_verdict),
                            32'(result_item.edge_verdict));
                check_field("resynced", 32'(want.resynced), 32'(result_item.resynced));
                check_field("byte_done", 32'(want.byte_done), 32'(result_item.byte_done));
                check_field("byte_value", 32'(want.byte_value), 32'(result_item.byte_value));
                check_field("bit_position", 32'(want.bit_position),
                            32'(result_item.bit_position));
                results_checked++;
                if (want.byte_done)
                    bytes_seen++;
                if (want.resynced)
                    resyncs_seen++;
                if (want.edge_verdict == xtkr_pkg::VERDICT_TOO_CLOSE)
                    too_close_seen++;
                if (want.edge_verdict == xtkr_pkg::VERDICT_TOO_SOON)
                    too_soon_seen++;
            end
        end
        if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            result_ready <= 1'b0;
        end
        else if (!rx_hold_done && results_checked >= 150 && pending_edges.size() > 20)
        begin
            rx_hold_done = 1'b1;
            rx_hold_left = 80;
            result_ready <= 1'b0;
        end
        else
        begin
            if (rx_mode_timer == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_timer = $urandom_range(16, 64);
            end
            else
                rx_mode_timer--;
            case (rx_mode)
                0: result_ready <= 1'b1;
                1: result_ready <= ($urandom_range(0, 1) == 1);
                2: result_ready <= (rx_cycle == 2'b00);
                default: result_ready <= ($urandom_range(0, 7) != 0);
            endcase
            rx_cycle = rx_cycle + 2'd1;
        end
    end

    task automatic push_edge(input logic [xtkr_pkg::TIME_W-1:0] stamp, input logic level);
        xtkr_pkg::in_item_t item;
        item.edge_time_us = stamp;
        item.data_level = level;
        pending_edges.push_back(item);
        edges_pushed++;
    endtask

    task automatic write_limit(input logic [1:0] reg_idx,
                               input logic [xtkr_pkg::GAP_W-1:0] value);
        logic [31:0] upper;
        upper = $urandom();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {upper[15:0], value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (reg_idx)
            xtkr_pkg::REG_MIN_EDGE_GAP: cfg_min_gap = value;
            xtkr_pkg::REG_MAX_EDGE_GAP: cfg_max_gap = value;
            default: cfg_idle_gap = value;
        endcase
    endtask

    task automatic set_limits(input logic [xtkr_pkg::GAP_W-1:0] min_gap,
                              input logic [xtkr_pkg::GAP_W-1:0] max_gap,
                              input logic [xtkr_pkg::GAP_W-1:0] idle_gap);
        write_limit(xtkr_pkg::REG_MIN_EDGE_GAP, min_gap);
        write_limit(xtkr_pkg::REG_MAX_EDGE_GAP, max_gap);
        write_limit(xtkr_pkg::REG_MIN_IDLE_GAP, idle_gap);
        settings_used++;
    endtask

    task automatic drain();
        while (edges_accepted != edges_pushed || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // A start bit after an idle gap, then the first nbits data bits, with the odd glitch between.
    task automatic send_bits(input logic [7:0] value, input int unsigned nbits);
        int unsigned idle_lo;
        idle_lo = 32'((cfg_idle_gap > cfg_min_gap) ? cfg_idle_gap : cfg_min_gap);
        stim_time += $urandom_range(idle_lo, idle_lo + 400);
        push_edge(stim_time, 1'($urandom_range(0, 1)));
        for (int i = 0; i < nbits; i++)
        begin
            if (cfg_min_gap != 0 && $urandom_range(0, 9) == 0)
                push_edge(stim_time + $urandom_range(0, cfg_min_gap - 1),
                          1'($urandom_range(0, 1)));
            stim_time += $urandom_range(cfg_min_gap, cfg_max_gap);
            push_edge(stim_time, value[i]);
        end
    endtask

    task automatic send_noise();
        logic [xtkr_pkg::TIME_W-1:0] stamp;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: stamp = '0;
                    1: stamp = '1;
                    default: stamp = $urandom();
                endcase
                push_edge(stamp, 1'($urandom_range(0, 1)));
                stim_time = stamp;
            end
            1:
            begin
                send_bits(8'($urandom_range(0, 255)), $urandom_range(1, 7));
                stim_time += cfg_max_gap + $urandom_range(1, 600);
                push_edge(stim_time, 1'($urandom_range(0, 1)));
            end
            2:
            begin
                if (cfg_idle_gap > cfg_min_gap)
                    push_edge(stim_time + $urandom_range(cfg_min_gap, cfg_idle_gap - 1),
                              1'($urandom_range(0, 1)));
            end
            default:
            begin
                if (cfg_min_gap != 0)
                    push_edge(stim_time + $urandom_range(0, cfg_min_gap - 1),
                              1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    task automatic random_traffic(input int unsigned n_edges);
        int unsigned stop_at;
        logic [7:0]  code;
        stop_at = edges_pushed + n_edges;
        while (edges_pushed < stop_at)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                case ($urandom_range(0, 9))
                    0: code = 8'h00;
                    1: code = 8'hFF;
                    default: code = 8'($urandom_range(0, 255));
                endcase
                send_bits(code, 8);
            end
            else
                send_noise();
        end
    endtask

    initial
    begin
        logic [7:0] code;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // The first edge needs no timing check; the byte crosses the timestamp wrap with gaps
        // at exactly the minimum and the maximum, and a too-close glitch after its first bit.
        code = 8'hA5;
        stim_time = 32'hFFFF_FE00;
        push_edge(stim_time, 1'b0);
        for (int i = 0; i < 8; i++)
        begin
            stim_time += (i % 2 == 1) ? 120 : 13;
            push_edge(stim_time, code[i]);
            if (i == 0)
                push_edge(stim_time + 12, 1'b1);
        end
        // A start bit too soon, then one exactly at the idle limit with the data line high.
        push_edge(stim_time + 50, 1'b0);
        stim_time += 200;
        push_edge(stim_time, 1'b1);
        stim_time += 20;
        push_edge(stim_time, 1'b1);
        stim_time += 20;
        push_edge(stim_time, 1'b0);
        // A long gap mid-byte resyncs and the same edge starts a new byte.
        stim_time += 500;
        push_edge(stim_time, 1'b0);
        stim_time += 20;
        push_edge(stim_time, 1'b1);
        // A gap that resyncs but is too short for a start bit.
        push_edge(stim_time + 150, 1'b0);
        stim_time += 300;
        push_edge(stim_time, 1'b0);
        for (int i = 0; i < 8; i++)
        begin
            stim_time += 40;
            push_edge(stim_time, 1'b1);
        end

        random_traffic(100);
        drain();
        set_limits(16'd0, 16'd65535, 16'd0);
        random_traffic(80);
        drain();
        set_limits(16'd65535, 16'd65535, 16'd65535);
        random_traffic(30);
        drain();
        set_limits(16'd0, 16'd0, 16'd0);
        random_traffic(60);
        drain();
        set_limits(16'd300, 16'd100, 16'd50);
        random_traffic(60);
        drain();
        set_limits(16'($urandom_range(1, 40)), 16'($urandom_range(60, 260)),
                   16'($urandom_range(0, 400)));
        random_traffic(80);
        drain();
        set_limits(xtkr_pkg::MIN_EDGE_GAP_RESET, xtkr_pkg::MAX_EDGE_GAP_RESET,
                   xtkr_pkg::MIN_IDLE_GAP_RESET);
        random_traffic(100);
        drain();
        repeat (8) @(posedge clk);

        $display("Checked %0d edge items under %0d limit settings: %0d bytes, %0d resyncs.",
                 results_checked, settings_used, bytes_seen, resyncs_seen);
        $display("Ignored %0d edges as too close and %0d as an early start bit.",
                 too_close_seen, too_soon_seen);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("xt_keyboard_receiver: match");
        else
            $display("xt_keyboard_receiver: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("xt_keyboard_receiver: mismatch");
        $finish;
    end

endmodule
